// File: hdl/sta_lta_max_ratio_unit_macros.svh
// Assertion macros used by the checker of the ratio unit.
`ifndef STA_LTA_MAX_RATIO_UNIT_MACROS_SVH
`define STA_LTA_MAX_RATIO_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define SLMR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sta_lta_max_ratio_unit: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define SLMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sta_lta_max_ratio_unit: next-cycle check failed");

`endif

// File: hdl/slmr_pkg.sv
`default_nettype none

package slmr_pkg;

  localparam int LONG_MAX  = 4096;
  localparam int RING_AW   = $clog2(LONG_MAX);
  localparam int SAMPLE_W  = 24;
  localparam int MAG_W     = 24;
  localparam int SUM_W     = 36;
  localparam int SHORT_W   = 12;
  localparam int LONG_W    = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W    = 48;
  localparam int MUL_W     = SUM_W + LONG_W;
  localparam int Q_FRAC    = 12;
  localparam int RATIO_W   = 24;
  localparam int DIV_STEPS = RATIO_W;
  localparam int ITER_W    = $clog2(DIV_STEPS);

  localparam logic [RATIO_W-1:0] RATIO_MAX     = '1;
  localparam logic [SHORT_W-1:0] SHORT_LEN_RST = SHORT_W'(100);
  localparam logic [LONG_W-1:0]  LONG_LEN_RST  = LONG_W'(1000);
  localparam logic [LONG_W-1:0]  LONG_LEN_MIN  = LONG_W'(2);
  localparam logic [LONG_W-1:0]  LONG_LEN_MAX  = LONG_W'(LONG_MAX);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_LEN,
    REG_LONG_LEN
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LONG,
    ST_UPDATE,
    ST_EVAL,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_DIV_INIT,
    ST_DIV,
    ST_CMP,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

// File: hdl/slmr_ram.sv
`default_nettype none

module slmr_ram #(
  parameter int Width = 24,
  parameter int Depth = 4096,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/sta_lta_max_ratio_unit.sv
// Channel   Signals                                   Word
// --------  ----------------------------------------  -------------------------
// in        in_valid_i / in_ready_o                   sample_i, last_sample_i
// out       out_valid_o / out_ready_i                 max_ratio_o, rejected_o
// cfg       cfg_we_i, cfg_idx_i, cfg_data_i           short_len, long_len
//
// A sample whose ratio is evaluated runs through the 24-step restoring divider unless the
// ratio saturates; the sequencer takes no new sample until it has finished the last one.
// The ring of magnitudes sits in one RAM with one read and one write port, read
// twice per sample. Reset clears the sums, count and best ratio; the RAM needs no
// clearing pass. A stalled output only holds the sequencer on a window's last word.
`default_nettype none

module sta_lta_max_ratio_unit
  import slmr_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                       last_sample_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic             [RATIO_W-1:0]  max_ratio_o,
  output logic                            rejected_o,
  input  wire logic                       cfg_we_i,
  input  wire logic        [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic        [CFG_W-1:0]    cfg_data_i
);

  state_e state_q, state_d;

  logic [SHORT_W-1:0] short_len_q, short_len_d;
  logic [LONG_W-1:0]  long_len_q, long_len_d;
  logic [SUM_W-1:0]   short_sum_q, short_sum_d;
  logic [SUM_W-1:0]   long_sum_q, long_sum_d;
  logic [LONG_W-1:0]  count_q, count_d;
  logic [RATIO_W-1:0] best_q, best_d;
  logic               zero_seen_q, zero_seen_d;
  logic [RING_AW-1:0] wr_pos_q, wr_pos_d;
  logic               out_valid_q, out_valid_d;

  logic [MAG_W-1:0]   mag_q, mag_d;
  logic               last_q, last_d;
  logic [PROD_W-1:0]  num_q, num_d;
  logic [PROD_W-1:0]  den_q, den_d;
  logic [PROD_W-1:0]  rem_q, rem_d;
  logic [RATIO_W-1:0] quo_q, quo_d;
  logic               sat_q, sat_d;
  logic [ITER_W-1:0]  iter_q, iter_d;
  logic [RATIO_W-1:0] max_ratio_q, max_ratio_d;
  logic               rejected_q, rejected_d;

  logic [LONG_W-1:0]  eff_long;
  logic [LONG_W-1:0]  short_cap;
  logic [SHORT_W-1:0] eff_short;
  logic [MAG_W-1:0]   mag_in;
  logic               in_accept;
  logic               short_full;
  logic               long_full;

  logic [SUM_W-1:0]   mul_a;
  logic [LONG_W-1:0]  mul_b;
  logic [MUL_W-1:0]   prod;
  logic [PROD_W:0]    trial;
  logic [PROD_W:0]    diff;
  logic               quo_bit;
  logic [RATIO_W-1:0] cand;
  logic               window_bad;

  logic               ram_we;
  logic [RING_AW-1:0] ram_raddr;
  logic [MAG_W-1:0]   ram_rdata;

  // Clamp the programmed lengths to the legal window range.
  always_comb begin
    if (long_len_q < LONG_LEN_MIN) begin
      eff_long = LONG_LEN_MIN;
    end else if (long_len_q > LONG_LEN_MAX) begin
      eff_long = LONG_LEN_MAX;
    end else begin
      eff_long = long_len_q;
    end
    short_cap = eff_long - LONG_W'(1);
    if (short_len_q == '0) begin
      eff_short = SHORT_W'(1);
    end else if ({1'b0, short_len_q} > short_cap) begin
      eff_short = short_cap[SHORT_W-1:0];
    end else begin
      eff_short = short_len_q;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign mag_in     = sample_i[SAMPLE_W-1] ? (~$unsigned(sample_i)) + MAG_W'(1)
                                           : $unsigned(sample_i);

  assign short_full = (count_q >= {1'b0, eff_short});
  assign long_full  = (count_q >= eff_long);

  // Leaving entries: short tap while idle, long tap on the following cycle.
  assign ram_raddr = (state_q == ST_IDLE) ? (wr_pos_q - RING_AW'(eff_short))
                                          : (wr_pos_q - eff_long[RING_AW-1:0]);
  assign ram_we    = (state_q == ST_UPDATE);

  slmr_ram #(
    .Width(MAG_W),
    .Depth(LONG_MAX)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_pos_q),
    .wdata_i(mag_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Shared multiplier: short_sum * L, then long_sum * S.
  assign mul_a = (state_q == ST_MUL_NUM) ? short_sum_q : long_sum_q;
  assign mul_b = (state_q == ST_MUL_NUM) ? eff_long : {1'b0, eff_short};
  assign prod  = mul_a * mul_b;

  // One restoring divide step.
  assign trial   = {rem_q, quo_q[RATIO_W-1]};
  assign diff    = trial - {1'b0, den_q};
  assign quo_bit = (trial >= {1'b0, den_q});

  assign cand       = sat_q ? RATIO_MAX : quo_q;
  assign window_bad = !long_full || zero_seen_q;

  always_comb begin
    state_d     = state_q;
    short_len_d = short_len_q;
    long_len_d  = long_len_q;
    short_sum_d = short_sum_q;
    long_sum_d  = long_sum_q;
    count_d     = count_q;
    best_d      = best_q;
    zero_seen_d = zero_seen_q;
    wr_pos_d    = wr_pos_q;
    out_valid_d = out_valid_q;
    mag_d       = mag_q;
    last_d      = last_q;
    num_d       = num_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    sat_d       = sat_q;
    iter_d      = iter_q;
    max_ratio_d = max_ratio_q;
    rejected_d  = rejected_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mag_d   = mag_in;
          last_d  = last_sample_i;
          state_d = ST_RD_LONG;
        end
      end
      ST_RD_LONG: begin
        short_sum_d = short_sum_q + SUM_W'(mag_q)
                    - (short_full ? SUM_W'(ram_rdata) : '0);
        state_d     = ST_UPDATE;
      end
      ST_UPDATE: begin
        long_sum_d = long_sum_q + SUM_W'(mag_q)
                   - (long_full ? SUM_W'(ram_rdata) : '0);
        wr_pos_d   = wr_pos_q + RING_AW'(1);
        if (!long_full) begin
          count_d = count_q + LONG_W'(1);
        end
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (long_full && !zero_seen_q) begin
          if (long_sum_q == '0) begin
            zero_seen_d = 1'b1;
            state_d     = ST_FINISH;
          end else begin
            state_d = ST_MUL_NUM;
          end
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_MUL_NUM: begin
        num_d   = prod[PROD_W-1:0];
        state_d = ST_MUL_DEN;
      end
      ST_MUL_DEN: begin
        den_d   = prod[PROD_W-1:0];
        state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        // Numerator is num * 2^Q_FRAC; its top part seeds the remainder.
        rem_d  = PROD_W'(num_q[PROD_W-1:Q_FRAC]);
        quo_d  = {num_q[Q_FRAC-1:0], {(RATIO_W - Q_FRAC){1'b0}}};
        sat_d  = (PROD_W'(num_q[PROD_W-1:Q_FRAC]) >= den_q);
        iter_d = '0;
        if (PROD_W'(num_q[PROD_W-1:Q_FRAC]) >= den_q) begin
          state_d = ST_CMP;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = quo_bit ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
        quo_d  = {quo_q[RATIO_W-2:0], quo_bit};
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(DIV_STEPS - 1)) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (cand > best_q) begin
          best_d = cand;
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          // Emit the window word and restart the window.
          out_valid_d = 1'b1;
          rejected_d  = window_bad;
          max_ratio_d = window_bad ? '0 : best_q;
          short_sum_d = '0;
          long_sum_d  = '0;
          count_d     = '0;
          best_d      = '0;
          zero_seen_d = 1'b0;
          wr_pos_d    = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SHORT_LEN: short_len_d = cfg_data_i[SHORT_W-1:0];
        REG_LONG_LEN:  long_len_d  = cfg_data_i[LONG_W-1:0];
        default:       short_len_d = short_len_q;
      endcase
      short_sum_d = '0;
      long_sum_d  = '0;
      count_d     = '0;
      best_d      = '0;
      zero_seen_d = 1'b0;
      wr_pos_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      short_len_q <= SHORT_LEN_RST;
      long_len_q  <= LONG_LEN_RST;
      short_sum_q <= '0;
      long_sum_q  <= '0;
      count_q     <= '0;
      best_q      <= '0;
      zero_seen_q <= 1'b0;
      wr_pos_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      short_len_q <= short_len_d;
      long_len_q  <= long_len_d;
      short_sum_q <= short_sum_d;
      long_sum_q  <= long_sum_d;
      count_q     <= count_d;
      best_q      <= best_d;
      zero_seen_q <= zero_seen_d;
      wr_pos_q    <= wr_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    last_q      <= last_d;
    num_q       <= num_d;
    den_q       <= den_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    sat_q       <= sat_d;
    iter_q      <= iter_d;
    max_ratio_q <= max_ratio_d;
    rejected_q  <= rejected_d;
  end

  assign out_valid_o = out_valid_q;
  assign max_ratio_o = max_ratio_q;
  assign rejected_o  = rejected_q;

endmodule

`default_nettype wire

// File: hdl/slmr_checker.sv
`default_nettype none
`include "sta_lta_max_ratio_unit_macros.svh"

module slmr_checker
  import slmr_pkg::*;
(
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic signed [SAMPLE_W-1:0]  sample_i,
  input wire logic                        last_sample_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic        [RATIO_W-1:0]   max_ratio_o,
  input wire logic                        rejected_o,
  input wire logic                        cfg_we_i,
  input wire logic        [CFG_IDX_W-1:0] cfg_idx_i,
  input wire logic        [CFG_W-1:0]     cfg_data_i
);

  // A rejected window carries no ratio.
  `SLMR_ASSERT_IMPL(a_reject_zero, clk_i, rst_ni, out_valid_o && rejected_o, max_ratio_o == '0)

  // Hold a stalled result word.
  `SLMR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(max_ratio_o) && $stable(rejected_o))

  // The sequencer is busy right after it takes a sample.
  `SLMR_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind sta_lta_max_ratio_unit slmr_checker u_slmr_checker (.*);

`default_nettype wire
